@@ hw/rtl/escape_time_fractal_iterator_core_defines.svh @@
// Assertion macros for the core top-level RTL file, the only RTL file that carries checks.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_CORE_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ETFI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ETFI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define ETFI_ASSERT(lbl, prop, msg)
`define ETFI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/etfi_pkg.sv @@
package etfi_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int FRAC_BITS      = 28;
    localparam int PIXEL_WIDTH    = 12;
    localparam int LIMIT_WIDTH    = 10;
    localparam int COUNT_WIDTH    = LIMIT_WIDTH + 1;
    localparam int SIZE_WIDTH     = 13;
    localparam int PROD_WIDTH     = COORD_WIDTH + PIXEL_WIDTH;
    localparam int CFG_IDX_WIDTH  = 4;
    localparam int CFG_DATA_WIDTH = 32;

    typedef logic signed [COORD_WIDTH-1:0]   t_coord;
    typedef logic signed [COORD_WIDTH:0]     t_coord_ext;
    typedef logic signed [2*COORD_WIDTH-1:0] t_wide;
    typedef logic [COORD_WIDTH-1:0]          t_mag;
    typedef logic [PROD_WIDTH-1:0]           t_prod;

    localparam t_coord COORD_MAX = t_coord'({1'b0, {(COORD_WIDTH - 1){1'b1}}});
    localparam t_coord COORD_MIN = t_coord'({1'b1, {(COORD_WIDTH - 1){1'b0}}});
    localparam t_prod  MAG_LIMIT = t_prod'({1'b0, {(COORD_WIDTH - 1){1'b1}}});

    // Escape bound of 4.0; when 4.0 cannot be represented the test never fires.
    localparam t_coord_ext FOUR_BOUND = (FRAC_BITS + 2 < COORD_WIDTH - 1) ?
        (t_coord_ext'(1) <<< (FRAC_BITS + 2)) : t_coord_ext'(COORD_MAX);

    localparam logic [LIMIT_WIDTH-1:0] RST_ITER_LIMIT  = LIMIT_WIDTH'(100);
    localparam t_coord                 RST_REAL_MIN    = t_coord'(-536870912);
    localparam t_coord                 RST_REAL_MAX    = t_coord'(268435456);
    localparam t_coord                 RST_IMAG_MIN    = t_coord'(-402653184);
    localparam t_coord                 RST_IMAG_MAX    = t_coord'(402653184);
    localparam logic [SIZE_WIDTH-1:0]  RST_WINDOW_SIZE = SIZE_WIDTH'(800);
    localparam t_coord                 RST_JULIA_C_RE  = t_coord'(-214748365);
    localparam t_coord                 RST_JULIA_C_IM  = t_coord'(42949673);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ITERATION_LIMIT = 4'd0,
        CFG_REAL_MIN        = 4'd1,
        CFG_REAL_MAX        = 4'd2,
        CFG_IMAG_MIN        = 4'd3,
        CFG_IMAG_MAX        = 4'd4,
        CFG_WINDOW_SIZE     = 4'd5,
        CFG_JULIA_C_REAL    = 4'd6,
        CFG_JULIA_C_IMAG    = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                   func;
        logic [PIXEL_WIDTH-1:0] pixel_x;
        logic [PIXEL_WIDTH-1:0] pixel_y;
        t_coord                 start_real;
        t_coord                 start_imag;
    } t_item;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] iteration_count;
        logic                   escaped;
    } t_result;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] iteration_limit;
        t_coord                 real_min;
        t_coord                 real_max;
        t_coord                 imag_min;
        t_coord                 imag_max;
        logic [SIZE_WIDTH-1:0]  window_size;
        t_coord                 julia_c_real;
        t_coord                 julia_c_imag;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic diff;
        logic div_start;
        logic map_wr;
        logic mul;
        logic scale;
        logic upd;
        logic axis;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic escape;
        logic last;
    } t_stat;

    function automatic t_coord sat_ext(input t_coord_ext x);
        t_coord r;
        if (x > t_coord_ext'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (x < t_coord_ext'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = t_coord'(x[COORD_WIDTH-1:0]);
        end
        return r;
    endfunction

    function automatic t_coord sat_add(input t_coord a, input t_coord b);
        return sat_ext(t_coord_ext'(a) + t_coord_ext'(b));
    endfunction

    function automatic t_coord sat_sub(input t_coord a, input t_coord b);
        return sat_ext(t_coord_ext'(a) - t_coord_ext'(b));
    endfunction

    // The arithmetic shift rounds the product toward minus infinity.
    function automatic t_coord qscale(input t_wide p);
        t_wide  s;
        t_coord r;
        s = p >>> FRAC_BITS;
        if (s > t_wide'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (s < t_wide'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = t_coord'(s[COORD_WIDTH-1:0]);
        end
        return r;
    endfunction

    function automatic t_mag mag(input t_coord a);
        t_coord n;
        n = -a;
        return a[COORD_WIDTH-1] ? t_mag'(n) : t_mag'(a);
    endfunction

    function automatic t_coord sat_mag(input logic neg, input t_prod q);
        t_coord v;
        t_coord r;
        v = t_coord'(q[COORD_WIDTH-1:0]);
        if (q > MAG_LIMIT) begin
            r = neg ? COORD_MIN : COORD_MAX;
        end else begin
            r = neg ? -v : v;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/escape_time_fractal_iterator_core.sv @@
// Channel      Direction  Handshake               Payload
// item         in         start, busy             i_item (t_item)
// result       out        o_done (one cycle)      o_result (t_result)
// config       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// An item keeps busy high from the capture edge through every iteration that it tests, each of which
// passes once through the shared multiply, scale and update stages. A Mandelbrot item first
// maps the pixel: one serial divider produces each 44-bit quotient at one bit per cycle, once
// per axis. The result strobe comes in the cycle after the last update, when busy is already
// low, and the receiver cannot stall it. Reset is synchronous and returns the configuration
// registers to their defaults.
`include "escape_time_fractal_iterator_core_defines.svh"

module escape_time_fractal_iterator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  etfi_pkg::t_item                      i_item,
    output logic                                 o_done,
    output etfi_pkg::t_result                    o_result,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [etfi_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [etfi_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    localparam int LW = etfi_pkg::LIMIT_WIDTH;
    localparam int SW = etfi_pkg::SIZE_WIDTH;
    localparam int CW = etfi_pkg::COORD_WIDTH;

    etfi_pkg::t_cfg  r_cfg;
    etfi_pkg::t_cmd  n_cmd;
    etfi_pkg::t_stat n_stat;
    logic [etfi_pkg::COUNT_WIDTH-1:0] n_count;
    logic            n_escaped;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iteration_limit <= etfi_pkg::RST_ITER_LIMIT;
            r_cfg.real_min        <= etfi_pkg::RST_REAL_MIN;
            r_cfg.real_max        <= etfi_pkg::RST_REAL_MAX;
            r_cfg.imag_min        <= etfi_pkg::RST_IMAG_MIN;
            r_cfg.imag_max        <= etfi_pkg::RST_IMAG_MAX;
            r_cfg.window_size     <= etfi_pkg::RST_WINDOW_SIZE;
            r_cfg.julia_c_real    <= etfi_pkg::RST_JULIA_C_RE;
            r_cfg.julia_c_imag    <= etfi_pkg::RST_JULIA_C_IM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (etfi_pkg::t_cfg_idx'(i_cfg_index))
                etfi_pkg::CFG_ITERATION_LIMIT: r_cfg.iteration_limit <= i_cfg_data[LW-1:0];
                etfi_pkg::CFG_REAL_MIN:        r_cfg.real_min     <= etfi_pkg::t_coord'(i_cfg_data[CW-1:0]);
                etfi_pkg::CFG_REAL_MAX:        r_cfg.real_max     <= etfi_pkg::t_coord'(i_cfg_data[CW-1:0]);
                etfi_pkg::CFG_IMAG_MIN:        r_cfg.imag_min     <= etfi_pkg::t_coord'(i_cfg_data[CW-1:0]);
                etfi_pkg::CFG_IMAG_MAX:        r_cfg.imag_max     <= etfi_pkg::t_coord'(i_cfg_data[CW-1:0]);
                etfi_pkg::CFG_WINDOW_SIZE:     r_cfg.window_size  <= i_cfg_data[SW-1:0];
                etfi_pkg::CFG_JULIA_C_REAL:    r_cfg.julia_c_real <= etfi_pkg::t_coord'(i_cfg_data[CW-1:0]);
                etfi_pkg::CFG_JULIA_C_IMAG:    r_cfg.julia_c_imag <= etfi_pkg::t_coord'(i_cfg_data[CW-1:0]);
                default: begin
                end
            endcase
        end
    end

    etfi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_func    (i_item.func),
        .i_stat    (n_stat),
        .o_cmd     (n_cmd),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_escaped (n_escaped)
    );

    etfi_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (n_cmd),
        .i_cfg   (r_cfg),
        .i_item  (i_item),
        .o_stat  (n_stat),
        .o_count (n_count)
    );

    assign o_result.iteration_count = n_count;
    assign o_result.escaped         = n_escaped;

    `ETFI_ASSERT(a_done_after_busy, o_done |-> $past(busy), "result strobe without a transaction in flight")
    `ETFI_ASSERT(a_accept_starts, (start && !busy) |=> busy, "accepted transaction did not start work")
    `ETFI_ASSERT(a_single_strobe, o_done |=> !o_done, "result strobe held for more than one cycle")
    `ETFI_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!busy && !o_done), "block not idle after reset")

endmodule

@@ hw/rtl/etfi_div.sv @@
module etfi_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  etfi_pkg::t_prod                  i_dividend,
    input  logic [etfi_pkg::SIZE_WIDTH-1:0]  i_divisor,
    output logic                             o_done,
    output etfi_pkg::t_prod                  o_quotient
);

    localparam int DW    = etfi_pkg::PROD_WIDTH;
    localparam int RW    = etfi_pkg::SIZE_WIDTH;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    r_dsr;
    logic [RW:0]      n_trial;
    logic [RW:0]      n_diff;
    logic [RW-1:0]    n_rem;
    logic             n_bit;

    always_comb begin
        n_trial = {r_rem, r_quo[DW-1]};
        n_diff  = n_trial - {1'b0, r_dsr};
        n_bit   = (n_trial >= {1'b0, r_dsr});
        n_rem   = n_bit ? n_diff[RW-1:0] : n_trial[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], n_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ hw/rtl/etfi_dpath.sv @@
module etfi_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  etfi_pkg::t_cmd                     i_cmd,
    input  etfi_pkg::t_cfg                     i_cfg,
    input  etfi_pkg::t_item                    i_item,
    output etfi_pkg::t_stat                    o_stat,
    output logic [etfi_pkg::COUNT_WIDTH-1:0]   o_count
);

    localparam int CW = etfi_pkg::COORD_WIDTH;
    localparam int PW = etfi_pkg::PIXEL_WIDTH;
    localparam int NW = etfi_pkg::COUNT_WIDTH;
    localparam int SW = etfi_pkg::SIZE_WIDTH;

    etfi_pkg::t_coord r_zr, r_zi, r_cr, r_ci;
    etfi_pkg::t_coord r_dr, r_di;
    etfi_pkg::t_coord r_sa, r_sb, r_sc;
    etfi_pkg::t_wide  r_pa, r_pb, r_pc;
    logic [PW-1:0]    r_px, r_py;
    logic [NW-1:0]    r_count;

    etfi_pkg::t_coord     n_base, n_sel_diff, n_map, n_t2, n_zr, n_zi;
    etfi_pkg::t_coord_ext n_mag2;
    etfi_pkg::t_prod      n_dividend, n_quotient;
    logic [PW-1:0]        n_pix;
    logic [SW-1:0]        n_divisor;
    logic                 n_div_done;

    always_comb begin
        n_sel_diff = i_cmd.axis ? r_di : r_dr;
        n_base     = i_cmd.axis ? i_cfg.imag_max : i_cfg.real_min;
        n_pix      = i_cmd.axis ? r_py : r_px;
        n_dividend = etfi_pkg::t_prod'(etfi_pkg::mag(n_sel_diff))
                   * etfi_pkg::t_prod'(n_pix);
        n_divisor  = (i_cfg.window_size == '0) ? SW'(1) : i_cfg.window_size;
        n_map      = etfi_pkg::sat_add(n_base,
                         etfi_pkg::sat_mag(n_sel_diff[CW-1], n_quotient));
        n_mag2     = etfi_pkg::t_coord_ext'(etfi_pkg::sat_add(r_sa, r_sb));
        n_t2       = etfi_pkg::sat_add(r_sc, r_sc);
        n_zi       = etfi_pkg::sat_add(n_t2, r_ci);
        n_zr       = etfi_pkg::sat_add(etfi_pkg::sat_sub(r_sa, r_sb), r_cr);
    end

    etfi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (n_div_done),
        .o_quotient (n_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px    <= i_item.pixel_x;
            r_py    <= i_item.pixel_y;
            r_count <= '0;
            if (i_item.func) begin
                r_zr <= i_item.start_real;
                r_zi <= i_item.start_imag;
                r_cr <= i_cfg.julia_c_real;
                r_ci <= i_cfg.julia_c_imag;
            end else begin
                r_zr <= '0;
                r_zi <= '0;
            end
        end
        if (i_cmd.diff) begin
            r_dr <= etfi_pkg::sat_sub(i_cfg.real_max, i_cfg.real_min);
            r_di <= etfi_pkg::sat_sub(i_cfg.imag_min, i_cfg.imag_max);
        end
        if (i_cmd.map_wr) begin
            if (i_cmd.axis) begin
                r_ci <= n_map;
            end else begin
                r_cr <= n_map;
            end
        end
        if (i_cmd.mul) begin
            r_pa <= etfi_pkg::t_wide'(r_zr) * etfi_pkg::t_wide'(r_zr);
            r_pb <= etfi_pkg::t_wide'(r_zi) * etfi_pkg::t_wide'(r_zi);
            r_pc <= etfi_pkg::t_wide'(r_zr) * etfi_pkg::t_wide'(r_zi);
        end
        if (i_cmd.scale) begin
            r_sa <= etfi_pkg::qscale(r_pa);
            r_sb <= etfi_pkg::qscale(r_pb);
            r_sc <= etfi_pkg::qscale(r_pc);
        end
        if (i_cmd.upd) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_count <= r_count + NW'(1);
        end
    end

    assign o_stat.div_done = n_div_done;
    assign o_stat.escape   = (n_mag2 > etfi_pkg::FOUR_BOUND);
    assign o_stat.last     = (r_count == {1'b0, i_cfg.iteration_limit});
    assign o_count         = r_count;

endmodule

@@ hw/rtl/etfi_ctrl.sv @@
module etfi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_func,
    input  etfi_pkg::t_stat i_stat,
    output etfi_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_done,
    output logic            o_escaped
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_DSTART,
        S_DIV,
        S_MUL,
        S_SCALE,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;
    logic   r_done, n_done;
    logic   r_esc, n_esc;

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_done     = 1'b0;
        n_esc      = r_esc;
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_axis     = 1'b0;
                    n_state    = i_func ? S_MUL : S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.map_wr = 1'b1;
                    if (r_axis) begin
                        n_state = S_MUL;
                    end else begin
                        n_axis  = 1'b1;
                        n_state = S_DSTART;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                if (i_stat.escape) begin
                    n_done  = 1'b1;
                    n_esc   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.upd = 1'b1;
                    if (i_stat.last) begin
                        n_done  = 1'b1;
                        n_esc   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
            r_done  <= 1'b0;
            r_esc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_done  <= n_done;
            r_esc   <= n_esc;
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_escaped = r_esc;

endmodule
